### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helper macros shared by the deframer RTL
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

### sv/bsfr_pkg.sv
// ----------------------------------------------------------------------------
// bsfr_pkg
// Types, byte codes and the body byte step of the byte stuffed frame receiver
// ----------------------------------------------------------------------------
package bsfr_pkg;

   // line codes
   localparam logic [7:0] SYNC_BYTE = 8'h7E;
   localparam logic [7:0] ESC_BYTE  = 8'h7D;
   localparam logic [7:0] ESC_7E    = 8'h5E;
   localparam logic [7:0] ESC_7D    = 8'h5D;

   // body layout
   localparam logic [7:0] BODY_IDX_CMD_HI = 8'd2;
   localparam logic [7:0] BODY_MIN        = 8'd4;
   localparam logic [7:0] PLEN_MAX        = 8'd127;

   // result kinds
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_REPORT  = 1'b1;

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_SHORT     = 3'd1,
      STATUS_BAD_SYSID = 3'd2,
      STATUS_BAD_SUM   = 3'd3,
      STATUS_TOO_LONG  = 3'd4
   } status_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  payload_byte;
      logic [15:0] command_id;
      logic [6:0]  payload_length;
      logic [2:0]  status;
      logic        last_of_run;
   } bsfr_result_type;

   // up to two results produced by one item
   typedef struct packed {
      logic [1:0]      count;
      bsfr_result_type r0;
      bsfr_result_type r1;
   } bsfr_push_type;

   typedef struct packed {
      logic        in_frame;
      logic        escape_pending;
      logic [7:0]  raw_count;
      logic [7:0]  body_count;
      logic [7:0]  held_byte;
      logic [7:0]  running_sum;
      logic [15:0] command_reg;
      logic        system_ok;
      logic        overflowed;
   } bsfr_state_type;

   typedef struct packed {
      bsfr_state_type state;
      logic           emit;
      logic [7:0]     emit_byte;
   } bsfr_accept_type;

   // take one unstuffed body byte; may release the previously held byte
   function automatic bsfr_accept_type accept_body(input bsfr_state_type s,
                                                   input logic [7:0] b,
                                                   input logic [7:0] sys_id,
                                                   input logic [7:0] max_body);
      bsfr_accept_type r;
      r           = '0;
      r.state     = s;
      r.emit_byte = s.held_byte;
      if (s.body_count >= max_body) begin
         r.state.overflowed = 1'b1;
      end else begin
         case (s.body_count)
            8'd0: begin
               r.state.system_ok   = (b == sys_id);
               r.state.running_sum = s.running_sum + b;
            end
            8'd1: begin
               r.state.command_reg = {s.command_reg[15:8], b};
               r.state.running_sum = s.running_sum + b;
            end
            BODY_IDX_CMD_HI: begin
               r.state.command_reg = {b, s.command_reg[7:0]};
               r.state.running_sum = s.running_sum + b;
            end
            default: begin
               if (s.body_count >= BODY_MIN) begin
                  r.emit              = 1'b1;
                  r.state.running_sum = s.running_sum + s.held_byte;
               end
               r.state.held_byte = b;
            end
         endcase
         r.state.body_count = s.body_count + 8'd1;
      end
      return r;
   endfunction

endpackage

### sv/byte_stuffed_frame_receiver.sv
// ----------------------------------------------------------------------------
// byte_stuffed_frame_receiver
// Byte stuffed frame deframer: unstuffs, checks and reports one frame at a time
// ----------------------------------------------------------------------------
// Path: line byte -> input register -> unstuff -> result queue -> result port.
// Throughput: one line byte per cycle while each byte yields at most one
//   result and the result port is not stalled; bytes yielding two results
//   are absorbed by the four entry result queue.
// Reset: synchronous; clears the frame state (hunting for a flag), the
//   system id register, the input valid flag and the result queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module byte_stuffed_frame_receiver import bsfr_pkg::*; #(
   parameter int MAX_BODY = 128
) (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_system_id,
   // line bytes
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   // results
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic [15:0] rsp_command_id,
   output logic [6:0]  rsp_payload_length,
   output logic [2:0]  rsp_status,
   output logic        rsp_last_of_run
);

   logic            in_valid_ff, in_valid_in;
   logic [7:0]      in_byte_ff;
   logic [7:0]      system_id_ff;
   logic            advance;
   logic [2:0]      q_count;
   bsfr_push_type   push;
   bsfr_result_type q_item;

   // configuration register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         system_id_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         system_id_ff <= csr_system_id;
      end
   end

   // input register advances when the queue has room for two results
   assign advance     = in_valid_ff && (q_count <= 3'd2);
   assign req_stall   = in_valid_ff && !advance;
   assign in_valid_in = req_valid ? 1'b1 : (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   bsfr_unstuff #(
      .MAX_BODY (MAX_BODY)
   ) u_unstuff (
      .clock      (clock),
      .reset      (reset),
      .step_valid (advance),
      .step_byte  (in_byte_ff),
      .system_id  (system_id_ff),
      .push       (push)
   );

   bsfr_result_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (!rsp_stall),
      .out_valid (rsp_valid),
      .out_item  (q_item),
      .count     (q_count)
   );

   // result fields
   assign rsp_kind           = q_item.kind;
   assign rsp_payload_byte   = q_item.payload_byte;
   assign rsp_command_id     = q_item.command_id;
   assign rsp_payload_length = q_item.payload_length;
   assign rsp_status         = q_item.status;
   assign rsp_last_of_run    = q_item.last_of_run;

   `ASSERT_ALWAYS(a_report_is_last, clock, reset,
      (rsp_valid && rsp_kind == KIND_REPORT) |-> rsp_last_of_run,
      "end report not last of its run")
   `ASSERT_ALWAYS(a_stall_only_when_held, clock, reset,
      req_stall |-> in_valid_ff,
      "input stalled with empty input register")
   `ASSERT_ALWAYS(a_payload_clean, clock, reset,
      (rsp_valid && rsp_kind == KIND_PAYLOAD) |-> (rsp_command_id == 16'd0),
      "payload item carries a command id")

endmodule

### sv/bsfr_unstuff.sv
// ----------------------------------------------------------------------------
// bsfr_unstuff
// Frame state and unstuffing: turns one line byte into up to two results
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bsfr_unstuff import bsfr_pkg::*; #(
   parameter int MAX_BODY = 128
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          step_valid,
   input  logic [7:0]    step_byte,
   input  logic [7:0]    system_id,
   output bsfr_push_type push
);

   localparam logic [7:0] MaxBody = 8'(MAX_BODY);

   bsfr_state_type  state_ff, state_in;
   bsfr_state_type  s0, s1, s2;
   bsfr_accept_type acc1, acc2;
   logic            en1, en2, rep;
   logic [7:0]      b1, b2;
   logic            e1, e2;
   logic [7:0]      plen_wide;
   bsfr_result_type pay1, pay2, report;
   logic [1:0]      cnt;

   // framing and escape decode
   always_comb begin
      s0  = state_ff;
      en1 = 1'b0;
      en2 = 1'b0;
      rep = 1'b0;
      b1  = ESC_BYTE;
      b2  = step_byte;
      if (!state_ff.in_frame) begin
         if (step_byte == SYNC_BYTE) begin
            s0          = '0;
            s0.in_frame = 1'b1;
         end
      end else if (step_byte == SYNC_BYTE) begin
         if (state_ff.raw_count == 8'd0) begin
            s0          = '0;
            s0.in_frame = 1'b1;
         end else begin
            // a dangling escape counts as a literal 7D
            en1               = state_ff.escape_pending;
            s0.escape_pending = 1'b0;
            rep               = 1'b1;
         end
      end else begin
         if (state_ff.raw_count != 8'hFF) begin
            s0.raw_count = state_ff.raw_count + 8'd1;
         end
         if (state_ff.escape_pending) begin
            s0.escape_pending = 1'b0;
            en1               = 1'b1;
            if (step_byte == ESC_7E) begin
               b1 = SYNC_BYTE;
            end else if (step_byte != ESC_7D) begin
               // unknown escape: literal 7D, then this byte as usual
               if (step_byte == ESC_BYTE) begin
                  s0.escape_pending = 1'b1;
               end else begin
                  en2 = 1'b1;
               end
            end
         end else if (step_byte == ESC_BYTE) begin
            s0.escape_pending = 1'b1;
         end else begin
            en1 = 1'b1;
            b1  = step_byte;
         end
      end
   end

   // up to two body bytes in sequence
   always_comb begin
      acc1 = accept_body(s0, b1, system_id, MaxBody);
      s1   = en1 ? acc1.state : s0;
      acc2 = accept_body(s1, b2, system_id, MaxBody);
      s2   = en2 ? acc2.state : s1;
      e1   = en1 & acc1.emit;
      e2   = en2 & acc2.emit;
   end

   // end of frame report
   always_comb begin
      report            = '0;
      report.kind       = KIND_REPORT;
      report.command_id = s2.command_reg;
      plen_wide         = (s2.body_count >= BODY_MIN) ? s2.body_count - BODY_MIN : 8'd0;
      report.payload_length = (plen_wide > PLEN_MAX) ? PLEN_MAX[6:0] : plen_wide[6:0];
      if (s2.body_count < BODY_MIN) begin
         report.status = STATUS_SHORT;
      end else if (!s2.system_ok) begin
         report.status = STATUS_BAD_SYSID;
      end else if (s2.overflowed) begin
         report.status = STATUS_TOO_LONG;
      end else if (s2.held_byte != s2.running_sum) begin
         report.status = STATUS_BAD_SUM;
      end else begin
         report.status = STATUS_OK;
      end
      report.last_of_run = 1'b1;
   end

   // pack results in order
   always_comb begin
      pay1              = '0;
      pay1.kind         = KIND_PAYLOAD;
      pay1.payload_byte = acc1.emit_byte;
      pay2              = '0;
      pay2.kind         = KIND_PAYLOAD;
      pay2.payload_byte = acc2.emit_byte;
      cnt = {1'b0, e1} + {1'b0, e2} + {1'b0, rep};
      if (!step_valid) begin
         cnt = 2'd0;
      end
      push.count = cnt;
      push.r0    = e1 ? pay1 : (e2 ? pay2 : report);
      push.r1    = (e1 && e2) ? pay2 : report;
      push.r0.last_of_run = (cnt == 2'd1);
      push.r1.last_of_run = 1'b1;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      if (step_valid) begin
         state_in = s2;
         if (rep) begin
            state_in.in_frame = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   `ASSERT_ALWAYS(a_esc_only_in_frame, clock, reset,
      !state_ff.in_frame |-> !state_ff.escape_pending,
      "escape pending outside a frame")
   `ASSERT_ALWAYS(a_body_bounded, clock, reset,
      state_ff.body_count <= MaxBody,
      "body count beyond maximum")
   `ASSERT_NEVER(a_report_ends_frame, clock, reset,
      $past(step_valid) && $past(rep) && state_ff.in_frame,
      "frame still open after report")

endmodule

### sv/bsfr_result_queue.sv
// ----------------------------------------------------------------------------
// bsfr_result_queue
// Four entry result queue, up to two pushes and one pop per cycle
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bsfr_result_queue import bsfr_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  bsfr_push_type   push,
   input  logic            pop,
   output logic            out_valid,
   output bsfr_result_type out_item,
   output logic [2:0]      count
);

   localparam int DEPTH = 4;

   bsfr_result_type      slot_ff [DEPTH];
   logic [1:0]           head_ff, head_in;
   logic [2:0]           count_ff, count_in;
   logic [1:0]           tail0, tail1;
   logic                 do_pop;

   assign out_valid = (count_ff != 3'd0);
   assign out_item  = slot_ff[head_ff];
   assign count     = count_ff;
   assign do_pop    = pop & out_valid;

   // pointers
   always_comb begin
      tail0    = head_ff + count_ff[1:0];
      tail1    = tail0 + 2'd1;
      head_in  = head_ff + {1'b0, do_pop};
      count_in = count_ff + {1'b0, push.count} - {2'b0, do_pop};
   end

   // storage
   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         if (push.count != 2'd0 && tail0 == 2'(i)) begin
            slot_ff[i] <= push.r0;
         end else if (push.count == 2'd2 && tail1 == 2'(i)) begin
            slot_ff[i] <= push.r1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   `ASSERT_ALWAYS(a_count_bounded, clock, reset,
      count_ff <= 3'(DEPTH),
      "result queue overrun")
   `ASSERT_NEVER(a_push_room, clock, reset,
      (push.count != 2'd0) && (count_ff > 3'(DEPTH - 2)),
      "push without room for two results")
   `ASSERT_NEVER(a_push_limit, clock, reset,
      push.count == 2'd3,
      "more than two results pushed in one cycle")

endmodule
